@@ rtl/ray_scene_nearest_hit_defines.svh @@
// Assertion macros for the ray_scene_nearest_hit block.
// Used by the top level; needs i_clk and i_rst_n in the using scope.
`ifndef RAY_SCENE_NEAREST_HIT_DEFINES_SVH
`define RAY_SCENE_NEAREST_HIT_DEFINES_SVH

// same-cycle implication, off during reset
`define RSNH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define RSNH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rsnh_pkg.sv @@
// Shared constants, scene ROM and types for ray_scene_nearest_hit.
// No dependencies; every other file but the defines header imports it.
package rsnh_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int NUM_SPHERES = 3;
    localparam int FRAC_BITS   = 16;
    localparam int ROM_PLANES  = 6;
    localparam int ROM_SPHERES = 3;

    localparam int N_PL  = (NUM_PLANES < ROM_PLANES) ? NUM_PLANES : ROM_PLANES;
    localparam int N_SP  = (NUM_SPHERES < ROM_SPHERES) ? NUM_SPHERES : ROM_SPHERES;
    localparam int N_OBJ = N_PL + N_SP;
    localparam int OBJ_W  = $clog2(N_OBJ);
    localparam int PIDX_W = $clog2(N_PL);
    localparam int SIDX_W = $clog2(N_SP);

    // item field widths
    localparam int ORG_W  = 24;
    localparam int DIR_W  = 18;
    localparam int EPS_W  = 16;
    localparam int DIST_W = 23;
    localparam int IDX_W  = 3;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;
    localparam longint DIST_MAX = 64'sd8388607;

    // datapath widths
    localparam int OC_W   = 25;
    localparam int P_W    = 43;
    localparam int BS_W   = 45;
    localparam int QQ_W   = 50;
    localparam int OCC_W  = 52;
    localparam int B_W    = 29;
    localparam int BB_W   = 58;
    localparam int DET_W  = 60;
    localparam int RAD_W  = 56;
    localparam int DEN_W  = 18;
    localparam int DVD_W  = 40;
    localparam int N_STEPS = 40;
    localparam int SRC_W  = 2 * N_STEPS;
    localparam int Q_W    = N_STEPS;
    localparam int REM_W  = 31;
    localparam int ACC_W  = Q_W + 2;
    localparam int ROOT_W = 30;
    localparam int T_W    = 42;

    localparam logic KIND_SPHERE = 1'b0;
    localparam logic KIND_PLANE  = 1'b1;

    function automatic int from_tenths(input int t);
        int s;
        s = t * (1 << FRAC_BITS);
        return (s >= 0) ? (s + 5) / 10 : -((-s + 5) / 10);
    endfunction

    // planes: axis (0 x, 1 y, 2 z), negated normal, offset
    localparam int PL_AXIS [ROM_PLANES] = '{0, 0, 1, 1, 2, 2};
    localparam int PL_NEG  [ROM_PLANES] = '{1, 0, 0, 1, 1, 0};
    localparam int PL_W    [ROM_PLANES] = '{from_tenths(26), from_tenths(26),
                                            from_tenths(20), from_tenths(20),
                                            from_tenths(28), from_tenths(79)};
    localparam int SP_CX [ROM_SPHERES] = '{from_tenths(-13), from_tenths(13), from_tenths(0)};
    localparam int SP_CY [ROM_SPHERES] = '{from_tenths(-12), from_tenths(-12), from_tenths(16)};
    localparam int SP_CZ [ROM_SPHERES] = '{from_tenths(-13), from_tenths(-2), from_tenths(0)};
    localparam longint SP_RR [ROM_SPHERES] = '{
        longint'(from_tenths(8)) * longint'(from_tenths(8)),
        longint'(from_tenths(8)) * longint'(from_tenths(8)),
        longint'(from_tenths(2)) * longint'(from_tenths(2))};

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    typedef struct packed {
        logic signed [ORG_W-1:0] ox;
        logic signed [ORG_W-1:0] oy;
        logic signed [ORG_W-1:0] oz;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
    } t_ray;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        idx;
        logic                    ok;
        logic                    neg;
        logic signed [B_W-1:0]   b;
    } t_tag;

    typedef struct packed {
        logic                    sq;
        logic [SRC_W-1:0]        src;
        logic [REM_W-1:0]        rem;
        logic [Q_W-1:0]          q;
        logic [DEN_W-1:0]        den;
        t_tag                    tag;
    } t_cell;

    typedef struct packed {
        t_tag                    tag;
        logic [DVD_W-1:0]        dvd;
        logic [DEN_W-1:0]        den;
        logic signed [OC_W-1:0]  ocx;
        logic signed [OC_W-1:0]  ocy;
        logic signed [OC_W-1:0]  ocz;
        logic signed [P_W-1:0]   px;
        logic signed [P_W-1:0]   py;
        logic signed [P_W-1:0]   pz;
        logic signed [QQ_W-1:0]  qx;
        logic signed [QQ_W-1:0]  qy;
        logic signed [QQ_W-1:0]  qz;
        logic signed [OCC_W-1:0] occ;
        logic signed [BB_W-1:0]  bb;
    } t_front;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] hdist;
        logic              kind;
        logic [IDX_W-1:0]  idx;
    } t_result;

endpackage

@@ rtl/rsnh_if.sv @@
// Handshake interfaces for rays in and hit results out.
// Depends on rsnh_pkg for field widths.
interface rsnh_ray_if;
    import rsnh_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ORG_W-1:0] origin_x;
    logic signed [ORG_W-1:0] origin_y;
    logic signed [ORG_W-1:0] origin_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rsnh_hit_if;
    import rsnh_pkg::*;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DIST_W-1:0] hit_distance;
    logic              object_kind;
    logic [IDX_W-1:0]  object_index;
    modport source (output valid, hit, hit_distance, object_kind, object_index,
                    input ready);
    modport sink (input valid, hit, hit_distance, object_kind, object_index,
                  output ready);
endinterface

@@ rtl/rsnh_cell.sv @@
// One step cell of the divide / square-root chain: one quotient bit
// or one root bit per cell. Depends on rsnh_pkg.
module rsnh_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  rsnh_pkg::t_cell i_cell,
    output logic           o_vld,
    output rsnh_pkg::t_cell o_cell
);
    import rsnh_pkg::*;

    logic [ACC_W-1:0] w_acc;
    logic [ACC_W-1:0] w_trial;
    logic [ACC_W-1:0] w_diff;
    logic             w_ge;
    t_cell            n_cell;
    logic             r_vld;
    t_cell            r_cell;

    always_comb begin
        if (i_cell.sq) begin
            // root: bring down two bits, trial is 4q+1
            w_acc   = ACC_W'({i_cell.rem, i_cell.src[SRC_W-1 -: 2]});
            w_trial = ACC_W'({i_cell.q, 2'b01});
        end else begin
            w_acc   = ACC_W'({i_cell.rem, i_cell.src[SRC_W-1]});
            w_trial = ACC_W'(i_cell.den);
        end
        w_ge   = (w_acc >= w_trial);
        w_diff = w_acc - w_trial;
        n_cell     = i_cell;
        n_cell.rem = w_ge ? w_diff[REM_W-1:0] : w_acc[REM_W-1:0];
        n_cell.q   = {i_cell.q[Q_W-2:0], w_ge};
        n_cell.src = i_cell.sq ? (i_cell.src << 2) : (i_cell.src << 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

@@ rtl/rsnh_front.sv @@
// Object sequencer and setup pipeline: issues one scene object per cycle,
// forms plane dividends and sphere discriminants for the cell chain. Uses rsnh_pkg.
module rsnh_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  rsnh_pkg::t_ray            i_ray,
    input  logic [rsnh_pkg::EPS_W-1:0] i_eps,
    output logic                      o_vld,
    output rsnh_pkg::t_cell           o_cell
);
    import rsnh_pkg::*;

    logic               r_busy;
    logic [OBJ_W-1:0]   r_obj;
    logic               r_v1, r_v2, r_v3, r_v4;
    t_front             r_s1, r_s2, r_s3, r_s4;
    t_front             n_s1, n_s2, n_s3, n_s4;

    logic [PIDX_W-1:0]        w_pi;
    logic [SIDX_W-1:0]        w_si;
    logic [SIDX_W-1:0]        w_si4;
    logic signed [ORG_W-1:0]  w_oa;
    logic signed [DIR_W-1:0]  w_da;
    logic signed [DIR_W:0]    w_den;
    logic signed [OC_W-1:0]   w_on;
    logic signed [OC_W:0]     w_num;
    logic signed [OC_W:0]     w_mag;
    logic signed [BS_W-1:0]   w_bsum;
    logic signed [DET_W-1:0]  w_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_obj  <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_obj  <= '0;
            end else if (r_busy) begin
                r_obj <= r_obj + 1'b1;
                if (r_obj == OBJ_W'(N_OBJ - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            r_v1 <= r_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 0: object select, plane setup, sphere offsets
    always_comb begin
        w_pi = r_obj[PIDX_W-1:0];
        w_si = SIDX_W'(r_obj - OBJ_W'(N_PL));
        case (PL_AXIS[w_pi])
            0: begin
                w_oa = i_ray.ox;
                w_da = i_ray.dx;
            end
            1: begin
                w_oa = i_ray.oy;
                w_da = i_ray.dy;
            end
            default: begin
                w_oa = i_ray.oz;
                w_da = i_ray.dz;
            end
        endcase
        w_den = (PL_NEG[w_pi] != 0) ? -((DIR_W+1)'(w_da)) : (DIR_W+1)'(w_da);
        w_on  = (PL_NEG[w_pi] != 0) ? -(OC_W'(w_oa)) : OC_W'(w_oa);
        w_num = (OC_W+1)'(PL_W[w_pi]) - (OC_W+1)'(w_on);
        w_mag = (w_num < 0) ? -w_num : w_num;

        n_s1 = '0;
        if (r_obj < OBJ_W'(N_PL)) begin
            n_s1.tag.kind = KIND_PLANE;
            n_s1.tag.idx  = IDX_W'(w_pi);
            n_s1.tag.ok   = (w_den > $signed({3'b000, i_eps}));
            n_s1.tag.neg  = (w_num < 0);
            n_s1.dvd      = DVD_W'(w_mag[OC_W-1:0]) << FRAC_BITS;
            n_s1.den      = w_den[DEN_W-1:0];
        end else begin
            n_s1.tag.kind = KIND_SPHERE;
            n_s1.tag.idx  = IDX_W'(w_si);
            n_s1.ocx      = OC_W'(SP_CX[w_si]) - OC_W'(i_ray.ox);
            n_s1.ocy      = OC_W'(SP_CY[w_si]) - OC_W'(i_ray.oy);
            n_s1.ocz      = OC_W'(SP_CZ[w_si]) - OC_W'(i_ray.oz);
        end
    end

    // stage 1: six products in parallel
    always_comb begin
        n_s2    = r_s1;
        n_s2.px = r_s1.ocx * i_ray.dx;
        n_s2.py = r_s1.ocy * i_ray.dy;
        n_s2.pz = r_s1.ocz * i_ray.dz;
        n_s2.qx = r_s1.ocx * r_s1.ocx;
        n_s2.qy = r_s1.ocy * r_s1.ocy;
        n_s2.qz = r_s1.ocz * r_s1.ocz;
    end

    // stage 2: b = floor(oc.d), oc.oc
    always_comb begin
        w_bsum    = BS_W'(r_s2.px) + BS_W'(r_s2.py) + BS_W'(r_s2.pz);
        n_s3      = r_s2;
        n_s3.occ  = OCC_W'(r_s2.qx) + OCC_W'(r_s2.qy) + OCC_W'(r_s2.qz);
        if (r_s2.tag.kind == KIND_SPHERE) begin
            n_s3.tag.b = B_W'(w_bsum >>> FRAC_BITS);
        end
    end

    // stage 3: b squared
    always_comb begin
        n_s4    = r_s3;
        n_s4.bb = r_s3.tag.b * r_s3.tag.b;
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_s2 <= n_s2;
        r_s3 <= n_s3;
        r_s4 <= n_s4;
    end

    // stage 4: discriminant, chain entry
    always_comb begin
        w_si4 = r_s4.tag.idx[SIDX_W-1:0];
        w_det = DET_W'(r_s4.bb) - DET_W'(r_s4.occ) + DET_W'(SP_RR[w_si4]);
        o_cell     = '0;
        o_cell.tag = r_s4.tag;
        if (r_s4.tag.kind == KIND_SPHERE) begin
            o_cell.sq     = 1'b1;
            o_cell.src    = SRC_W'(w_det[RAD_W-1:0]);
            o_cell.tag.ok = !w_det[DET_W-1];
        end else begin
            o_cell.sq  = 1'b0;
            o_cell.src = {r_s4.dvd, (SRC_W-DVD_W)'(0)};
            o_cell.den = r_s4.den;
        end
    end

    assign o_vld = r_v4;

endmodule

@@ rtl/ray_scene_nearest_hit.sv @@
// Nearest ray hit against a fixed scene of six planes and three spheres.
// Rays enter on i_ray, one result per ray leaves on o_hit.
// Register min_distance is written through i_cfg_we / i_cfg_data.
//
// A ray is taken on i_ray when valid and ready are both high; ready is high
// only while no ray is in flight. The nine scene objects are then issued one
// per cycle into a four-register setup pipeline and a chain of 40 identical
// step cells. Each cell produces one quotient bit of a plane distance or one
// bit of a sphere root, so every object passes through all 40 cells.
// The result register is loaded in the flush state after the last object has
// left the chain; the next ray is taken only after the return to idle, so the
// block takes no new ray before it is done with the last one.
// The result register holds until o_hit.ready; a new ray may be in flight
// meanwhile, and it waits at the end of its run while the old result is held.
// Reset (synchronous, active low) empties the pipeline, drops o_hit.valid and
// sets min_distance to 7. Write min_distance only while no ray is in flight.
`include "ray_scene_nearest_hit_defines.svh"

module ray_scene_nearest_hit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rsnh_pkg::EPS_W-1:0]  i_cfg_data,
    rsnh_ray_if.sink                    i_ray,
    rsnh_hit_if.source                  o_hit
);
    import rsnh_pkg::*;

    t_state              r_state;
    logic [EPS_W-1:0]    r_eps;
    t_ray                r_ray;
    logic [OBJ_W-1:0]    r_cnt;
    logic                r_found;
    logic signed [T_W-1:0] r_best;
    logic                r_kind;
    logic [IDX_W-1:0]    r_idx;
    logic                r_out_vld;
    t_result             r_out;

    logic                w_acc;
    logic                w_free;
    logic                w_front_vld;
    t_cell               w_front_cell;
    logic                w_cvld [N_STEPS+1];
    t_cell               w_cell [N_STEPS+1];
    logic                w_exit_vld;
    t_cell               w_exit;

    logic signed [T_W-1:0] w_eps;
    logic signed [T_W-1:0] w_bx;
    logic signed [T_W-1:0] w_sx;
    logic signed [T_W-1:0] w_qv;
    logic signed [T_W-1:0] w_lo;
    logic signed [T_W-1:0] w_hi;
    logic signed [T_W-1:0] w_t;
    logic                  w_cand;
    t_result               w_res;

    assign w_acc       = i_ray.valid && i_ray.ready;
    assign w_free      = !r_out_vld || o_hit.ready;
    assign i_ray.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ray <= '{ox: i_ray.origin_x, oy: i_ray.origin_y, oz: i_ray.origin_z,
                       dx: i_ray.dir_x, dy: i_ray.dir_y, dz: i_ray.dir_z};
        end
    end

    rsnh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc),
        .i_ray   (r_ray),
        .i_eps   (r_eps),
        .o_vld   (w_front_vld),
        .o_cell  (w_front_cell)
    );

    assign w_cvld[0] = w_front_vld;
    assign w_cell[0] = w_front_cell;

    for (genvar g = 0; g < N_STEPS; g++) begin : g_chain
        rsnh_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_cvld[g]),
            .i_cell  (w_cell[g]),
            .o_vld   (w_cvld[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    assign w_exit_vld = w_cvld[N_STEPS];
    assign w_exit     = w_cell[N_STEPS];

    // distance of the object leaving the chain
    always_comb begin
        w_eps = $signed(T_W'(r_eps));
        w_bx  = T_W'(w_exit.tag.b);
        w_sx  = $signed(T_W'(w_exit.q[ROOT_W-1:0]));
        w_qv  = $signed(T_W'(w_exit.q));
        w_lo  = w_bx - w_sx;
        w_hi  = w_bx + w_sx;
        w_t    = w_qv;
        w_cand = 1'b0;
        if (w_exit.tag.kind == KIND_PLANE) begin
            w_t    = w_exit.tag.neg ? -w_qv : w_qv;
            w_cand = w_exit.tag.ok;
        end else if (w_exit.tag.ok) begin
            if (w_lo > w_eps) begin
                w_t    = w_lo;
                w_cand = 1'b1;
            end else if (w_hi > w_eps) begin
                w_t    = w_hi;
                w_cand = 1'b1;
            end
        end
    end

    // saturated result
    always_comb begin
        w_res = '0;
        if (r_found) begin
            w_res.hit  = 1'b1;
            w_res.kind = r_kind;
            w_res.idx  = r_idx;
            if (r_best < 0) begin
                w_res.hdist = '0;
            end else if (r_best > T_W'(DIST_MAX)) begin
                w_res.hdist = DIST_W'(DIST_MAX);
            end else begin
                w_res.hdist = r_best[DIST_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if ((r_state == S_FLUSH) && w_free) begin
                r_out_vld <= 1'b1;
            end else if (o_hit.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_RUN: begin
                    if (w_exit_vld) begin
                        // strict compare keeps the earlier object on a tie
                        if (w_cand && (!r_found || (w_t < r_best))) begin
                            r_found <= 1'b1;
                        end
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == OBJ_W'(N_OBJ - 1)) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RUN) && w_exit_vld && w_cand && (!r_found || (w_t < r_best))) begin
            r_best <= w_t;
            r_kind <= w_exit.tag.kind;
            r_idx  <= w_exit.tag.idx;
        end
        if ((r_state == S_FLUSH) && w_free) begin
            r_out <= w_res;
        end
    end

    assign o_hit.valid        = r_out_vld;
    assign o_hit.hit          = r_out.hit;
    assign o_hit.hit_distance = r_out.hdist;
    assign o_hit.object_kind  = r_out.kind;
    assign o_hit.object_index = r_out.idx;

    `RSNH_ASSERT_SAME(a_exit_in_run, w_exit_vld, r_state == S_RUN, "object left chain outside a run")
    `RSNH_ASSERT_NEXT(a_flush_loads, (r_state == S_FLUSH) && w_free, r_out_vld && (r_state == S_IDLE), "flush did not load result")
    `RSNH_ASSERT_SAME(a_miss_zero, r_out_vld && !r_out.hit, (r_out.hdist == '0) && (r_out.kind == KIND_SPHERE) && (r_out.idx == '0), "miss result not all zero")
    `RSNH_ASSERT_SAME(a_cnt_bound, r_state == S_RUN, r_cnt < OBJ_W'(N_OBJ), "object count past scene size")

endmodule
